/* rtl/core/bphc_pkg.sv */
// Shared types and constants for the button press/hold/click event unit.
// Used by every module under rtl/core; depends on nothing.
package bphc_pkg;

    localparam int MAX_BUTTONS = 8;
    localparam int TIME_BITS   = 32;
    localparam int SLOT_BITS   = 3;
    localparam int COUNT_BITS  = 4;
    localparam int CLICK_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 40;

    localparam logic [COUNT_BITS-1:0] MAX_BUTTONS_C = COUNT_BITS'(MAX_BUTTONS);

    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_MIN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_BTN = 2'd2;

    localparam logic [TIME_BITS-1:0]  HOLD_TIME_RESET  = 32'd1000;
    localparam logic [CLICK_BITS-1:0] CLICK_MIN_RESET  = 16'd50;
    localparam logic [COUNT_BITS-1:0] ACTIVE_BTN_RESET = 4'd8;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_HOLD  = 2'd2,
        EV_CLICK = 2'd3
    } event_t;

    // One classified poll, as it travels from the front to the back.
    typedef struct packed {
        logic                 slot_ok;
        logic [SLOT_BITS-1:0] slot;
        logic                 pressed;
        logic [TIME_BITS-1:0] now;
    } poll_t;

endpackage

/* rtl/core/bphc_front.sv */
// Front end: unpacks an input item and marks whether its slot is in use.
// Depends on bphc_pkg.
module bphc_front
    import bphc_pkg::*;
(
    input  logic [IN_TDATA_BITS-1:0] tdata,
    input  logic [COUNT_BITS-1:0]    active_buttons,
    output poll_t                    poll
);

    logic [COUNT_BITS-1:0] limit;
    logic [SLOT_BITS-1:0]  slot;

    assign slot  = tdata[SLOT_BITS-1:0];
    // Clamp the active count to the table size.
    assign limit = (active_buttons > MAX_BUTTONS_C) ? MAX_BUTTONS_C : active_buttons;

    always_comb
    begin
        poll.slot    = slot;
        poll.pressed = tdata[SLOT_BITS];
        poll.now     = tdata[SLOT_BITS+TIME_BITS:SLOT_BITS+1];
        poll.slot_ok = ({1'b0, slot} < limit);
    end

endmodule

/* rtl/core/bphc_queue.sv */
// Two-entry queue between front and back; push and pop may share a cycle.
// Depends on bphc_pkg for the poll_t item type.
module bphc_queue
    import bphc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  poll_t push_item,
    output logic  not_full,
    input  logic  pop,
    output poll_t pop_item,
    output logic  not_empty
);

    poll_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/bphc_back.sv */
// Back end: button table, event decision and the output register.
// Depends on bphc_pkg.
module bphc_back
    import bphc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  poll_t                     poll,
    input  logic                      poll_valid,
    output logic                      poll_take,
    input  logic [TIME_BITS-1:0]      hold_time_ms,
    input  logic [CLICK_BITS-1:0]     click_min_ms,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [OUT_TDATA_BITS-1:0] out_data
);

    logic [MAX_BUTTONS-1:0] down_reg;
    logic [MAX_BUTTONS-1:0] seen_reg;
    logic [TIME_BITS-1:0]   start_reg [MAX_BUTTONS];
    logic [TIME_BITS-1:0]   last_reg  [MAX_BUTTONS];

    logic                   valid_reg;
    event_t                 event_reg;
    logic [TIME_BITS-1:0]   held_reg;

    logic                   down;
    logic                   seen;
    logic [TIME_BITS-1:0]   dur;
    logic [TIME_BITS-1:0]   since_hold;
    logic                   hold_due;
    logic                   repeat_due;

    event_t                 event_next;
    logic [TIME_BITS-1:0]   held_next;
    logic                   down_next;
    logic                   seen_next;
    logic                   start_wr;
    logic                   last_wr;

    assign poll_take = poll_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = {{(OUT_TDATA_BITS-TIME_BITS-2){1'b0}}, held_reg, event_reg};

    assign down       = down_reg[poll.slot];
    assign seen       = seen_reg[poll.slot];
    assign dur        = poll.now - start_reg[poll.slot];
    assign since_hold = poll.now - last_reg[poll.slot];
    assign hold_due   = (dur >= hold_time_ms);
    assign repeat_due = (since_hold >= hold_time_ms);

    always_comb
    begin
        event_next = EV_NONE;
        held_next  = '0;
        down_next  = down;
        seen_next  = seen;
        start_wr   = 1'b0;
        last_wr    = 1'b0;
        if (poll.slot_ok)
        begin
            if (poll.pressed && !down)
            begin
                down_next  = 1'b1;
                seen_next  = 1'b0;
                start_wr   = 1'b1;
                event_next = EV_PRESS;
            end
            else if (poll.pressed)
            begin
                held_next = dur;
                if (hold_due && (!seen || repeat_due))
                begin
                    seen_next  = 1'b1;
                    last_wr    = 1'b1;
                    event_next = EV_HOLD;
                end
            end
            else if (down)
            begin
                down_next = 1'b0;
                if (!seen && (dur >= {{(TIME_BITS-CLICK_BITS){1'b0}}, click_min_ms}))
                begin
                    event_next = EV_CLICK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg  <= '0;
            seen_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (poll_take)
            begin
                down_reg[poll.slot] <= down_next;
                seen_reg[poll.slot] <= seen_next;
                valid_reg           <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Times are read only while the matching flag is set, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            event_reg <= event_next;
            held_reg  <= held_next;
            if (start_wr)
            begin
                start_reg[poll.slot] <= poll.now;
            end
            if (last_wr)
            begin
                last_reg[poll.slot] <= poll.now;
            end
        end
    end

endmodule

/* rtl/core/button_press_hold_click_events_unit.sv */
// Top level of the button press/hold/click event unit: config registers,
// front, queue and back. Depends on bphc_pkg, bphc_front, bphc_queue, bphc_back.
//
//  port group   dir  handshake          payload
//  s_*          in   s_tvalid/s_tready  s_tdata: button_slot, pressed_level, now_ms
//  m_*          out  m_tvalid/m_tready  m_tdata: event_code, held_for_ms
//  cfg_*        in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while m_tready does not stall the output; an accepted
// item is first written into the queue, then the table update writes its result into
// the output register.
// The table update is a read-modify-write of one slot, which sets the rate.
// Reset clears the button flags and loads the register defaults.
// The two-entry queue lets input keep flowing for two items while m_tready is low.
module button_press_hold_click_events_unit
    import bphc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [2:0] button_slot, [3] pressed_level,
                                                 // [35:4] now_ms, [39:36] zero
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [1:0] event_code, [33:2] held_for_ms,
                                                 // [39:34] zero
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [TIME_BITS-1:0]      cfg_data
);

    logic [TIME_BITS-1:0]  hold_time_reg;
    logic [CLICK_BITS-1:0] click_min_reg;
    logic [COUNT_BITS-1:0] active_btn_reg;

    poll_t front_poll;
    poll_t queue_poll;
    logic  queue_not_full;
    logic  queue_not_empty;
    logic  back_take;

    assign cfg_ready = 1'b1;
    assign s_tready  = queue_not_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg  <= HOLD_TIME_RESET;
            click_min_reg  <= CLICK_MIN_RESET;
            active_btn_reg <= ACTIVE_BTN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOLD_TIME:  hold_time_reg  <= cfg_data;
                REG_CLICK_MIN:  click_min_reg  <= cfg_data[CLICK_BITS-1:0];
                REG_ACTIVE_BTN: active_btn_reg <= cfg_data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    bphc_front u_front (
        .tdata          (s_tdata),
        .active_buttons (active_btn_reg),
        .poll           (front_poll)
    );

    bphc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && queue_not_full),
        .push_item (front_poll),
        .not_full  (queue_not_full),
        .pop       (back_take),
        .pop_item  (queue_poll),
        .not_empty (queue_not_empty)
    );

    bphc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll         (queue_poll),
        .poll_valid   (queue_not_empty),
        .poll_take    (back_take),
        .hold_time_ms (hold_time_reg),
        .click_min_ms (click_min_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (m_tdata)
    );

endmodule

/* dv/tb.sv */
// Testbench for button_press_hold_click_events_unit: polls, register writes, event checks.
// Depends on bphc_pkg and the RTL top level; checks every result against an in-bench predictor.
module tb
    import bphc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;

    // Per-slot press tracker plus the queue of events the block still owes.
    class press_event_board;
        typedef struct {
            event_t               ev;
            logic [TIME_BITS-1:0] held;
        } poll_event_t;

        logic [TIME_BITS-1:0]  hold_ms;
        logic [CLICK_BITS-1:0] click_ms;
        logic [COUNT_BITS-1:0] active;
        bit                    down[MAX_BUTTONS];
        logic [TIME_BITS-1:0]  start_ms[MAX_BUTTONS];
        bit                    hold_seen[MAX_BUTTONS];
        logic [TIME_BITS-1:0]  last_hold_ms[MAX_BUTTONS];
        poll_event_t           owed_events[$];
        int                    errors;

        function new();
            hold_ms  = HOLD_TIME_RESET;
            click_ms = CLICK_MIN_RESET;
            active   = ACTIVE_BTN_RESET;
            errors   = 0;
            for (int i = 0; i < MAX_BUTTONS; i++)
            begin
                down[i]         = 0;
                start_ms[i]     = '0;
                hold_seen[i]    = 0;
                last_hold_ms[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TIME_BITS-1:0] data);
            case (idx)
                REG_HOLD_TIME:  hold_ms  = data;
                REG_CLICK_MIN:  click_ms = data[CLICK_BITS-1:0];
                REG_ACTIVE_BTN: active   = data[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_poll(logic [SLOT_BITS-1:0] slot, logic lvl,
                                logic [TIME_BITS-1:0] now);
            logic [COUNT_BITS-1:0] limit;
            logic [TIME_BITS-1:0]  dur;
            poll_event_t           r;
            limit  = (active > MAX_BUTTONS_C) ? MAX_BUTTONS_C : active;
            r.ev   = EV_NONE;
            r.held = '0;
            dur    = '0;
            if ({1'b0, slot} < limit)
            begin
                if (down[slot])
                    dur = now - start_ms[slot];
                if (lvl && !down[slot])
                begin
                    down[slot]         = 1;
                    start_ms[slot]     = now;
                    hold_seen[slot]    = 0;
                    last_hold_ms[slot] = '0;
                    r.ev               = EV_PRESS;
                end
                else if (lvl)
                begin
                    if (dur >= hold_ms)
                    begin
                        if (!hold_seen[slot])
                        begin
                            hold_seen[slot]    = 1;
                            last_hold_ms[slot] = now;
                            r.ev               = EV_HOLD;
                        end
                        else if (TIME_BITS'(now - last_hold_ms[slot]) >= hold_ms)
                        begin
                            last_hold_ms[slot] = now;
                            r.ev               = EV_HOLD;
                        end
                    end
                end
                else if (down[slot])
                begin
                    down[slot] = 0;
                    if (!hold_seen[slot] && dur >= {16'd0, click_ms})
                        r.ev = EV_CLICK;
                end
                if (down[slot])
                    r.held = now - start_ms[slot];
            end
            owed_events.push_back(r);
        endfunction

        function int outstanding();
            return owed_events.size();
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_BITS-1:0] tdata);
            poll_event_t r;
            if (owed_events.size() == 0)
            begin
                report($sformatf("unexpected result tdata=%h", tdata));
            end
            else
            begin
                r = owed_events.pop_front();
                if (tdata[1:0] != r.ev)
                    report($sformatf("event_code got %0d want %0d", tdata[1:0], r.ev));
                if (tdata[33:2] != r.held)
                    report($sformatf("held_for_ms got %0d want %0d", tdata[33:2], r.held));
                if (tdata[39:34] != '0)
                    report($sformatf("pad bits got %h", tdata[39:34]));
            end
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;   // [2:0] button_slot, [3] pressed_level,
                                               // [35:4] now_ms, [39:36] zero
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;        // [1:0] event_code, [33:2] held_for_ms,
                                               // [39:34] zero
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [TIME_BITS-1:0]      cfg_data = '0;

    press_event_board board = new();
    bit               no_idle = 0;
    int               cycles = 0;
    logic [TIME_BITS-1:0] clock_ms = '0;
    logic [TIME_BITS-1:0] step_span = 32'd100;
    bit               want_down[MAX_BUTTONS];

    button_press_hold_click_events_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("button_press_hold_click_events_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Receiver: runs of ready, then stalls of random length.
    initial
    begin
        int run;
        int stall;
        forever
        begin
            run   = $urandom_range(1, 12);
            stall = gap_len();
            @(posedge clk);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
        end
    end

    // Keep valid high across back-to-back items; drop it only for a real gap.
    task automatic send_poll(logic [SLOT_BITS-1:0] slot, logic lvl, logic [TIME_BITS-1:0] now);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {4'd0, now, lvl, slot};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        board.note_poll(slot, lvl, now);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [TIME_BITS-1:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.write_reg(idx, data);
    endtask

    // Mostly press/hold/release sequences on a rising clock; the rest is noise.
    task automatic run_polls(int count);
        logic [SLOT_BITS-1:0] slot;
        logic                 lvl;
        logic [TIME_BITS-1:0] now;
        for (int i = 0; i < count; i++)
        begin
            slot = SLOT_BITS'($urandom_range(0, MAX_BUTTONS - 1));
            if ($urandom_range(0, 9) < 8)
            begin
                clock_ms += $urandom_range(0, step_span);
                now = clock_ms;
                if (want_down[slot])
                    lvl = ($urandom_range(0, 4) != 0);
                else
                    lvl = 1'($urandom_range(0, 1));
            end
            else
            begin
                lvl = 1'($urandom_range(0, 1));
                now = $urandom;
            end
            want_down[slot] = lvl;
            send_poll(slot, lvl, now);
        end
    endtask

    initial
    begin
        logic [TIME_BITS-1:0] hold;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: press, hold and repeat, wrapped click, click edge, wrapped hold edge.
        send_poll(3'd0, 1'b1, 32'd100);
        send_poll(3'd0, 1'b1, 32'd600);
        send_poll(3'd0, 1'b1, 32'd1100);
        send_poll(3'd0, 1'b1, 32'd1500);
        send_poll(3'd0, 1'b1, 32'd2100);
        send_poll(3'd0, 1'b0, 32'd2200);
        send_poll(3'd0, 1'b0, 32'd2300);
        send_poll(3'd1, 1'b1, 32'hFFFF_FFF0);
        send_poll(3'd1, 1'b0, 32'h0000_0030);
        send_poll(3'd2, 1'b1, 32'd500);
        send_poll(3'd2, 1'b0, 32'd549);
        send_poll(3'd2, 1'b1, 32'd600);
        send_poll(3'd2, 1'b0, 32'd650);
        send_poll(3'd7, 1'b1, 32'hFFFF_FFFF);
        send_poll(3'd7, 1'b1, 32'h0000_03E6);
        send_poll(3'd7, 1'b1, 32'h0000_03E7);
        settle();

        // Unused register write, zero hold time, zero click time, active count past the table size.
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_HOLD_TIME, 32'd0);
        write_reg(REG_CLICK_MIN, {16'($urandom_range(0, 16'hFFFF)), 16'd0});
        write_reg(REG_ACTIVE_BTN, {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'd15});
        send_poll(3'd7, 1'b1, 32'h0000_0500);
        send_poll(3'd7, 1'b1, 32'h0000_0500);
        send_poll(3'd7, 1'b0, 32'h0000_0500);
        no_idle   = 1;
        step_span = 32'd20;
        run_polls(40);
        settle();

        // Largest hold and click times; no active slots, then all of them.
        no_idle = 0;
        write_reg(REG_HOLD_TIME, 32'hFFFF_FFFF);
        write_reg(REG_CLICK_MIN, {16'($urandom_range(0, 16'hFFFF)), 16'hFFFF});
        write_reg(REG_ACTIVE_BTN, 32'd0);
        send_poll(3'd0, 1'b1, 32'd5);
        send_poll(3'd3, 1'b0, 32'd7);
        settle();
        write_reg(REG_ACTIVE_BTN, {28'd0, ACTIVE_BTN_RESET});
        send_poll(3'd4, 1'b1, 32'd1);
        send_poll(3'd4, 1'b1, 32'd0);
        send_poll(3'd4, 1'b0, 32'd5);
        send_poll(3'd5, 1'b1, 32'd0);
        send_poll(3'd5, 1'b0, 32'd65535);
        send_poll(3'd6, 1'b1, 32'd0);
        send_poll(3'd6, 1'b0, 32'd65534);
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            hold = ($urandom_range(0, 3) == 0) ? 32'd1 : $urandom_range(2, 300);
            write_reg(REG_HOLD_TIME, hold);
            write_reg(REG_CLICK_MIN, $urandom_range(0, 150));
            write_reg(REG_ACTIVE_BTN, ($urandom_range(0, 3) == 0) ?
                                      $urandom_range(0, 15) : $urandom_range(6, 8));
            no_idle   = (phase % 3 == 1);
            step_span = hold * 2 / 3 + 1;
            clock_ms  = (phase == 5) ? 32'hFFFF_FF00 : $urandom;
            run_polls(50);
            settle();
        end

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("button_press_hold_click_events_unit test passed");
        else
            $display("button_press_hold_click_events_unit test failed");
        $finish;
    end

endmodule
